[hw/rtl/tspp_pkg.sv]
`timescale 1ns / 1ps

package tspp_pkg;

   localparam int INT_BITS_DEF    = 20;
   localparam int FRAC_BITS_DEF   = 12;
   localparam int FRAC_DIGITS_DEF = 4;
   localparam int OUT_W           = 35;
   localparam int QUEUE_DEPTH     = 4;

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_INT,
      PH_FRAC,
      PH_STOP
   } phase_type;

   localparam logic [7:0] CH_NUL    = 8'd0;
   localparam logic [7:0] CH_TAB    = 8'd9;
   localparam logic [7:0] CH_LF     = 8'd10;
   localparam logic [7:0] CH_VT     = 8'd11;
   localparam logic [7:0] CH_FF     = 8'd12;
   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_QUOTE  = 8'd34;
   localparam logic [7:0] CH_HASH   = 8'd35;
   localparam logic [7:0] CH_LPAREN = 8'd40;
   localparam logic [7:0] CH_RPAREN = 8'd41;
   localparam logic [7:0] CH_PLUS   = 8'd43;
   localparam logic [7:0] CH_COMMA  = 8'd44;
   localparam logic [7:0] CH_DASH   = 8'd45;
   localparam logic [7:0] CH_POINT  = 8'd46;
   localparam logic [7:0] CH_ZERO   = 8'd48;
   localparam logic [7:0] CH_NINE   = 8'd57;
   localparam logic [7:0] CH_COLON  = 8'd58;
   localparam logic [7:0] CH_DEL    = 8'd127;

   localparam logic KIND_TIME   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic longint unsigned pow10(input int n);
      longint unsigned p;
      p = 1;
      for (int i = 0; i < n; i++) p = p * 10;
      return p;
   endfunction

endpackage

[hw/rtl/text_sample_pair_parser.sv]
`timescale 1ns / 1ps

// Channel  Ports                                      Dir  Word
// req      req_valid, req_stall, req_in_byte          in   one text byte
// rsp      rsp_valid, rsp_stall, rsp_token_kind,      out  one parsed token
//          rsp_number_out
//
// One byte is taken every cycle while the token queue has room.
// A token reaches rsp from its terminating byte through the queue, one divider
// stage per quotient bit, the sum stage and the output register.
// Back end sustains one token per cycle; rsp_stall freezes the whole divider pipe.
// Synchronous active-high reset clears the parse state, queue and valid bits.

module text_sample_pair_parser #(
   parameter int INT_BITS    = tspp_pkg::INT_BITS_DEF,
   parameter int FRAC_BITS   = tspp_pkg::FRAC_BITS_DEF,
   parameter int FRAC_DIGITS = tspp_pkg::FRAC_DIGITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_in_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_token_kind,
   output logic [tspp_pkg::OUT_W-1:0] rsp_number_out
);

   localparam int DW = $clog2(tspp_pkg::pow10(FRAC_DIGITS) + 1);
   localparam int CW = $clog2(FRAC_DIGITS + 1);
   localparam int QW = 1 + INT_BITS + DW + CW;

   tspp_pkg::qstat_type  q_stat;
   logic                 accept, q_push, q_pop;
   logic                 f_kind;
   logic [INT_BITS-1:0]  f_int;
   logic [DW-1:0]        f_frac;
   logic [CW-1:0]        f_count;
   logic [QW-1:0]        q_wr, q_rd;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;
   assign q_wr      = {f_kind, f_int, f_frac, f_count};

   tspp_front #(
      .INT_BITS    (INT_BITS),
      .FRAC_DIGITS (FRAC_DIGITS),
      .DW          (DW),
      .CW          (CW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_in_byte),
      .push       (q_push),
      .push_kind  (f_kind),
      .push_int   (f_int),
      .push_frac  (f_frac),
      .push_count (f_count)
   );

   tspp_queue #(
      .W (QW)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr),
      .pop     (q_pop),
      .rd_data (q_rd),
      .stat    (q_stat)
   );

   tspp_back #(
      .INT_BITS    (INT_BITS),
      .FRAC_BITS   (FRAC_BITS),
      .FRAC_DIGITS (FRAC_DIGITS),
      .DW          (DW),
      .CW          (CW)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_stat.empty),
      .q_kind         (q_rd[QW-1]),
      .q_int          (q_rd[QW-2 -: INT_BITS]),
      .q_frac         (q_rd[DW+CW-1 -: DW]),
      .q_count        (q_rd[CW-1:0]),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_token_kind (rsp_token_kind),
      .rsp_number_out (rsp_number_out)
   );

   a_push_room : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("token pushed into full queue");

   a_pop_data : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("token popped from empty queue");

   a_term_push : assert property (@(posedge clock) disable iff (reset)
      accept && (req_in_byte == tspp_pkg::CH_SPACE || req_in_byte == tspp_pkg::CH_DASH ||
                 req_in_byte == tspp_pkg::CH_LF || req_in_byte == tspp_pkg::CH_QUOTE)
      |-> q_push)
      else $error("terminator word did not queue a token");

endmodule

[hw/rtl/tspp_front.sv]
`timescale 1ns / 1ps

module tspp_front #(
   parameter int INT_BITS    = tspp_pkg::INT_BITS_DEF,
   parameter int FRAC_DIGITS = tspp_pkg::FRAC_DIGITS_DEF,
   parameter int DW          = $clog2(tspp_pkg::pow10(FRAC_DIGITS) + 1),
   parameter int CW          = $clog2(FRAC_DIGITS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   output logic                push,
   output logic                push_kind,
   output logic [INT_BITS-1:0] push_int,
   output logic [DW-1:0]       push_frac,
   output logic [CW-1:0]       push_count
);

   localparam int IW = INT_BITS + 4;
   localparam int FW = DW + 4;

   tspp_pkg::phase_type phase_ff, phase_in;
   logic [INT_BITS-1:0] int_ff, int_in;
   logic [DW-1:0]       frac_ff, frac_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                sign_ff, sign_in;

   logic          drop, term_time, term_sample, is_point, is_digit, is_ws, is_plus;
   logic [IW-1:0] int_x10;
   logic [FW-1:0] frac_x10;

   always_comb begin
      drop = (in_byte == tspp_pkg::CH_NUL) ||
             (in_byte >= tspp_pkg::CH_COLON && in_byte <= tspp_pkg::CH_DEL) ||
             (in_byte == tspp_pkg::CH_LPAREN) || (in_byte == tspp_pkg::CH_RPAREN) ||
             (in_byte == tspp_pkg::CH_CR) || (in_byte == tspp_pkg::CH_HASH);
      term_time   = (in_byte == tspp_pkg::CH_SPACE) || (in_byte == tspp_pkg::CH_DASH);
      term_sample = (in_byte == tspp_pkg::CH_LF) || (in_byte == tspp_pkg::CH_QUOTE);
      is_point    = (in_byte == tspp_pkg::CH_POINT) || (in_byte == tspp_pkg::CH_COMMA);
      is_digit    = (in_byte >= tspp_pkg::CH_ZERO) && (in_byte <= tspp_pkg::CH_NINE);
      is_ws       = (in_byte == tspp_pkg::CH_TAB) || (in_byte == tspp_pkg::CH_VT) ||
                    (in_byte == tspp_pkg::CH_FF);
      is_plus     = (in_byte == tspp_pkg::CH_PLUS);

      int_x10  = IW'({int_ff, 3'b000}) + IW'({int_ff, 1'b0}) + IW'(in_byte[3:0]);
      frac_x10 = FW'({frac_ff, 3'b000}) + FW'({frac_ff, 1'b0}) + FW'(in_byte[3:0]);

      push        = accept && !drop && (term_time || term_sample);
      push_kind   = term_sample ? tspp_pkg::KIND_SAMPLE : tspp_pkg::KIND_TIME;
      push_int    = int_ff;
      push_frac   = frac_ff;
      push_count  = count_ff;

      phase_in = phase_ff;
      int_in   = int_ff;
      frac_in  = frac_ff;
      count_in = count_ff;
      sign_in  = sign_ff;

      if (accept && !drop) begin
         if (term_time || term_sample) begin
            phase_in = tspp_pkg::PH_LEAD;
            int_in   = '0;
            frac_in  = '0;
            count_in = '0;
            sign_in  = 1'b0;
         end else begin
            unique case (phase_ff)
               tspp_pkg::PH_LEAD: begin
                  if (is_ws && !sign_ff) begin
                     phase_in = tspp_pkg::PH_LEAD;
                  end else if (is_plus && !sign_ff) begin
                     sign_in = 1'b1;
                  end else if (is_digit) begin
                     int_in   = INT_BITS'(in_byte[3:0]);
                     phase_in = tspp_pkg::PH_INT;
                  end else if (is_point) begin
                     phase_in = tspp_pkg::PH_FRAC;
                  end else begin
                     phase_in = tspp_pkg::PH_STOP;
                  end
               end
               tspp_pkg::PH_INT: begin
                  if (is_digit) begin
                     int_in = (int_x10 > IW'({INT_BITS{1'b1}})) ? {INT_BITS{1'b1}}
                                                                  : int_x10[INT_BITS-1:0];
                  end else if (is_point) begin
                     phase_in = tspp_pkg::PH_FRAC;
                  end else begin
                     phase_in = tspp_pkg::PH_STOP;
                  end
               end
               tspp_pkg::PH_FRAC: begin
                  if (is_digit) begin
                     if (count_ff < CW'(FRAC_DIGITS)) begin
                        frac_in  = frac_x10[DW-1:0];
                        count_in = count_ff + 1'b1;
                     end
                  end else begin
                     phase_in = tspp_pkg::PH_STOP;
                  end
               end
               tspp_pkg::PH_STOP: begin
                  phase_in = tspp_pkg::PH_STOP;
               end
               default: phase_in = tspp_pkg::PH_STOP;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tspp_pkg::PH_LEAD;
         int_ff   <= '0;
         frac_ff  <= '0;
         count_ff <= '0;
         sign_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         int_ff   <= int_in;
         frac_ff  <= frac_in;
         count_ff <= count_in;
         sign_ff  <= sign_in;
      end
   end

endmodule

[hw/rtl/tspp_queue.sv]
`timescale 1ns / 1ps

module tspp_queue #(
   parameter int W = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [W-1:0]        wr_data,
   input  logic                pop,
   output logic [W-1:0]        rd_data,
   output tspp_pkg::qstat_type stat
);

   localparam int DEPTH = tspp_pkg::QUEUE_DEPTH;
   localparam int AW    = $clog2(DEPTH);

   logic [W-1:0] mem [0:DEPTH-1];
   logic [AW:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW:0]  rd_ptr_ff, rd_ptr_in;

   always_comb begin
      stat.empty = (wr_ptr_ff == rd_ptr_ff);
      stat.full  = (wr_ptr_ff[AW] != rd_ptr_ff[AW]) &&
                   (wr_ptr_ff[AW-1:0] == rd_ptr_ff[AW-1:0]);
      rd_data    = mem[rd_ptr_ff[AW-1:0]];
      wr_ptr_in  = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff[AW-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

endmodule

[hw/rtl/tspp_back.sv]
`timescale 1ns / 1ps

module tspp_back #(
   parameter int INT_BITS    = tspp_pkg::INT_BITS_DEF,
   parameter int FRAC_BITS   = tspp_pkg::FRAC_BITS_DEF,
   parameter int FRAC_DIGITS = tspp_pkg::FRAC_DIGITS_DEF,
   parameter int DW          = $clog2(tspp_pkg::pow10(FRAC_DIGITS) + 1),
   parameter int CW          = $clog2(FRAC_DIGITS + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  logic                       q_kind,
   input  logic [INT_BITS-1:0]        q_int,
   input  logic [DW-1:0]              q_frac,
   input  logic [CW-1:0]              q_count,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_token_kind,
   output logic [tspp_pkg::OUT_W-1:0] rsp_number_out
);

   localparam int QB   = FRAC_BITS + 1;
   localparam int NW   = DW + FRAC_BITS + 1;
   localparam int T    = INT_BITS + FRAC_BITS;
   localparam int PW   = T + 3;
   localparam int MW   = (PW > tspp_pkg::OUT_W) ? PW : tspp_pkg::OUT_W;
   localparam int NTAB = 2 ** CW;
   localparam logic [MW-1:0] OMAX = MW'({tspp_pkg::OUT_W{1'b1}});

   logic [DW-1:0] den_tab [0:NTAB-1];

   for (genvar i = 0; i < NTAB; i++) begin : g_den
      assign den_tab[i] = (i <= FRAC_DIGITS) ? DW'(tspp_pkg::pow10(i)) : DW'(1);
   end

   logic [QB:0]         vld_ff, vld_in;
   logic [NW-1:0]       rem_ff  [0:QB];
   logic [NW-1:0]       rem_in  [0:QB];
   logic [QB-1:0]       quo_ff  [0:QB];
   logic [QB-1:0]       quo_in  [0:QB];
   logic [DW-1:0]       den_ff  [0:QB];
   logic [DW-1:0]       den_in  [0:QB];
   logic [INT_BITS-1:0] int_ff  [0:QB];
   logic [INT_BITS-1:0] int_in  [0:QB];
   logic [QB:0]         kind_ff, kind_in;
   logic [NW-1:0]       den_sh  [0:QB-1];
   logic [QB-1:0]       ge;

   logic                tot_vld_ff, tot_kind_ff;
   logic [T-1:0]        tot_ff, tot_in;
   logic [T:0]          sum;
   logic                rsp_valid_ff, rsp_kind_ff;
   logic [tspp_pkg::OUT_W-1:0] rsp_num_ff, rsp_num_in;
   logic [PW-1:0]       prod;
   logic [MW-1:0]       val;
   logic                adv;
   logic [DW-1:0]       den_sel;

   always_comb begin
      adv     = !rsp_valid_ff || !rsp_stall;
      pop     = adv && !q_empty;
      den_sel = den_tab[q_count];

      vld_in[0]  = pop;
      rem_in[0]  = NW'({q_frac, {FRAC_BITS{1'b0}}}) + NW'(den_sel >> 1);
      quo_in[0]  = '0;
      den_in[0]  = den_sel;
      int_in[0]  = q_int;
      kind_in[0] = q_kind;

      // one quotient bit per stage, MSB first
      for (int s = 0; s < QB; s++) begin
         den_sh[s]    = NW'(den_ff[s]) << (QB - 1 - s);
         ge[s]        = rem_ff[s] >= den_sh[s];
         rem_in[s+1]  = ge[s] ? rem_ff[s] - den_sh[s] : rem_ff[s];
         quo_in[s+1]  = quo_ff[s] | (QB'(ge[s]) << (QB - 1 - s));
         den_in[s+1]  = den_ff[s];
         int_in[s+1]  = int_ff[s];
         kind_in[s+1] = kind_ff[s];
         vld_in[s+1]  = vld_ff[s];
      end

      sum    = (T+1)'({int_ff[QB], {FRAC_BITS{1'b0}}}) + (T+1)'(quo_ff[QB]);
      tot_in = sum[T] ? {T{1'b1}} : sum[T-1:0];

      prod       = PW'({tot_ff, 2'b00}) + PW'(tot_ff);
      val        = tot_kind_ff ? MW'(prod) : MW'(tot_ff);
      rsp_num_in = (val > OMAX) ? tspp_pkg::OUT_W'(OMAX) : tspp_pkg::OUT_W'(val);

      rsp_valid      = rsp_valid_ff;
      rsp_token_kind = rsp_kind_ff;
      rsp_number_out = rsp_num_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         tot_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         tot_vld_ff   <= vld_ff[QB];
         rsp_valid_ff <= tot_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s <= QB; s++) begin
            rem_ff[s] <= rem_in[s];
            quo_ff[s] <= quo_in[s];
            den_ff[s] <= den_in[s];
            int_ff[s] <= int_in[s];
         end
         kind_ff     <= kind_in;
         tot_ff      <= tot_in;
         tot_kind_ff <= kind_ff[QB];
         rsp_num_ff  <= rsp_num_in;
         rsp_kind_ff <= tot_kind_ff;
      end
   end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int INT_BITS     = tspp_pkg::INT_BITS_DEF;
   localparam int FRAC_BITS    = tspp_pkg::FRAC_BITS_DEF;
   localparam int FRAC_DIGITS  = tspp_pkg::FRAC_DIGITS_DEF;
   localparam int OUT_W        = tspp_pkg::OUT_W;
   localparam int RANDOM_BYTES = 800;
   localparam int SETTLE       = FRAC_BITS + 24;
   localparam int CYCLE_LIMIT  = 200000;
   localparam longint unsigned OUT_MAX = (64'd1 << OUT_W) - 1;

   typedef struct packed {
      logic             kind;
      logic [OUT_W-1:0] value;
   } parsed_token_type;

   typedef struct packed {
      logic [7:0]       code;
      logic             typed;
      logic             kind;
      logic [OUT_W-1:0] value;
   } script_row_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic [7:0]       req_in_byte = 8'd0;
   logic             rsp_stall   = 1'b0;
   logic             req_stall;
   logic             rsp_valid;
   logic             rsp_token_kind;
   logic [OUT_W-1:0] rsp_number_out;

   parsed_token_type    pending_tokens[$];
   tspp_pkg::phase_type lex_phase  = tspp_pkg::PH_LEAD;
   longint unsigned     whole_part = 0;
   int unsigned         frac_value = 0;
   int unsigned         frac_len   = 0;
   bit                  plus_seen  = 1'b0;

   bit steady       = 1'b0;
   int errors       = 0;
   int bytes_sent   = 0;
   int times_seen   = 0;
   int samples_seen = 0;
   int cycle_count  = 0;

   text_sample_pair_parser u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_token_kind (rsp_token_kind),
      .rsp_number_out (rsp_number_out)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned fixed_value();
      longint unsigned den;
      longint unsigned frac;
      longint unsigned total;
      longint unsigned limit;
      frac = 0;
      if (frac_len > 0) begin
         den = 1;
         for (int i = 0; i < frac_len; i++) den = den * 10;
         frac = ((64'(frac_value) << FRAC_BITS) + den / 2) / den;
      end
      total = (whole_part << FRAC_BITS) + frac;
      limit = (64'd1 << (INT_BITS + FRAC_BITS)) - 1;
      return (total > limit) ? limit : total;
   endfunction

   function automatic void scan_byte(input logic [7:0] code, output bit made,
                                     output parsed_token_type tok);
      logic [7:0]      c;
      longint unsigned v;
      longint unsigned imax;
      bit              is_digit;
      made = 1'b0;
      tok  = '0;
      c    = code;
      if (c == tspp_pkg::CH_NUL || (c >= tspp_pkg::CH_COLON && c <= tspp_pkg::CH_DEL) ||
          c == tspp_pkg::CH_LPAREN || c == tspp_pkg::CH_RPAREN || c == tspp_pkg::CH_CR ||
          c == tspp_pkg::CH_HASH)
         return;
      if (c == tspp_pkg::CH_SPACE) c = tspp_pkg::CH_DASH;
      else if (c == tspp_pkg::CH_LF) c = tspp_pkg::CH_QUOTE;
      else if (c == tspp_pkg::CH_COMMA) c = tspp_pkg::CH_POINT;
      if (c == tspp_pkg::CH_DASH || c == tspp_pkg::CH_QUOTE) begin
         v = fixed_value();
         if (c == tspp_pkg::CH_QUOTE) v = v * 5;
         if (v > OUT_MAX) v = OUT_MAX;
         made       = 1'b1;
         tok.kind   = (c == tspp_pkg::CH_QUOTE) ? tspp_pkg::KIND_SAMPLE : tspp_pkg::KIND_TIME;
         tok.value  = v[OUT_W-1:0];
         lex_phase  = tspp_pkg::PH_LEAD;
         whole_part = 0;
         frac_value = 0;
         frac_len   = 0;
         plus_seen  = 1'b0;
         return;
      end
      is_digit = (c >= tspp_pkg::CH_ZERO && c <= tspp_pkg::CH_NINE);
      imax     = (64'd1 << INT_BITS) - 1;
      case (lex_phase)
         tspp_pkg::PH_LEAD: begin
            if ((c == tspp_pkg::CH_TAB || c == tspp_pkg::CH_VT || c == tspp_pkg::CH_FF) &&
                !plus_seen) begin
            end else if (c == tspp_pkg::CH_PLUS && !plus_seen) begin
               plus_seen = 1'b1;
            end else if (is_digit) begin
               whole_part = c - tspp_pkg::CH_ZERO;
               lex_phase  = tspp_pkg::PH_INT;
            end else if (c == tspp_pkg::CH_POINT) begin
               lex_phase = tspp_pkg::PH_FRAC;
            end else begin
               lex_phase = tspp_pkg::PH_STOP;
            end
         end
         tspp_pkg::PH_INT: begin
            if (is_digit) begin
               v          = whole_part * 10 + (c - tspp_pkg::CH_ZERO);
               whole_part = (v > imax) ? imax : v;
            end else if (c == tspp_pkg::CH_POINT) begin
               lex_phase = tspp_pkg::PH_FRAC;
            end else begin
               lex_phase = tspp_pkg::PH_STOP;
            end
         end
         tspp_pkg::PH_FRAC: begin
            if (is_digit) begin
               if (frac_len < FRAC_DIGITS) begin
                  frac_value = frac_value * 10 + (c - tspp_pkg::CH_ZERO);
                  frac_len++;
               end
            end else begin
               lex_phase = tspp_pkg::PH_STOP;
            end
         end
         default: begin
         end
      endcase
   endfunction

   task automatic push_byte(input logic [7:0] code, input logic typed, input logic kind,
                            input logic [OUT_W-1:0] value);
      bit               made;
      parsed_token_type tok;
      while (!steady && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= code;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      scan_byte(code, made, tok);
      if (made) begin
         if (typed) begin
            tok.kind  = kind;
            tok.value = value;
         end
         pending_tokens.push_back(tok);
      end
   endtask

   task automatic push_digit();
      push_byte(8'(tspp_pkg::CH_ZERO + $urandom_range(9)), 1'b0, 1'b0, '0);
   endtask

   // bytes the front-end filter throws away
   task automatic maybe_junk();
      logic [7:0] code;
      if ($urandom_range(99) >= 8) return;
      case ($urandom_range(5))
         0: code = tspp_pkg::CH_NUL;
         1: code = tspp_pkg::CH_LPAREN;
         2: code = tspp_pkg::CH_RPAREN;
         3: code = tspp_pkg::CH_CR;
         4: code = tspp_pkg::CH_HASH;
         default: code = 8'($urandom_range(tspp_pkg::CH_COLON, tspp_pkg::CH_DEL));
      endcase
      push_byte(code, 1'b0, 1'b0, '0);
   endtask

   task automatic emit_token();
      int         n;
      logic [7:0] code;
      if ($urandom_range(99) < 12) begin
         repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)), 1'b0, 1'b0, '0);
         return;
      end
      repeat ($urandom_range(2)) begin
         n = $urandom_range(2);
         push_byte(n == 0 ? tspp_pkg::CH_TAB : (n == 1 ? tspp_pkg::CH_VT : tspp_pkg::CH_FF),
                   1'b0, 1'b0, '0);
      end
      if ($urandom_range(99) < 30) push_byte(tspp_pkg::CH_PLUS, 1'b0, 1'b0, '0);
      n = ($urandom_range(9) == 0) ? $urandom_range(7, 9) : $urandom_range(4);
      repeat (n) begin
         maybe_junk();
         push_digit();
      end
      if ($urandom_range(99) < 60) begin
         push_byte($urandom_range(1) ? tspp_pkg::CH_POINT : tspp_pkg::CH_COMMA,
                   1'b0, 1'b0, '0);
         repeat ($urandom_range(6)) begin
            maybe_junk();
            push_digit();
         end
      end
      if ($urandom_range(99) < 8) begin
         push_byte(8'($urandom_range(255)), 1'b0, 1'b0, '0);
         repeat ($urandom_range(2)) push_digit();
      end
      case ($urandom_range(3))
         0: code = tspp_pkg::CH_SPACE;
         1: code = tspp_pkg::CH_DASH;
         2: code = tspp_pkg::CH_LF;
         default: code = tspp_pkg::CH_QUOTE;
      endcase
      push_byte(code, 1'b0, 1'b0, '0);
   endtask

   task automatic drain_tokens();
      req_valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
   endtask

   task automatic flag_mismatch(input string msg);
      $display("%0t: %s", $realtime, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_stall <= !reset && !steady && ($urandom_range(99) < 25);
   end

   always @(posedge clock) begin
      parsed_token_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_tokens.size() == 0) begin
            flag_mismatch($sformatf("unexpected word kind %0d value 0x%0h",
                                    rsp_token_kind, rsp_number_out));
         end else begin
            want = pending_tokens.pop_front();
            if (rsp_token_kind !== want.kind)
               flag_mismatch($sformatf("token_kind %0d, want %0d", rsp_token_kind, want.kind));
            if (rsp_number_out !== want.value)
               flag_mismatch($sformatf("number_out 0x%0h, want 0x%0h",
                                       rsp_number_out, want.value));
            if (want.kind == tspp_pkg::KIND_SAMPLE) samples_seen++;
            else times_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout, %0d words outstanding", pending_tokens.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      script_row_type opening[32];
      int             tokens_made;
      opening = '{
         '{8'hFF, 1'b0, 1'b0, '0},
         '{tspp_pkg::CH_DASH, 1'b1, tspp_pkg::KIND_TIME, 35'd0},
         '{tspp_pkg::CH_VT, 1'b0, 1'b0, '0}, '{tspp_pkg::CH_PLUS, 1'b0, 1'b0, '0},
         '{tspp_pkg::CH_TAB, 1'b0, 1'b0, '0}, '{"7", 1'b0, 1'b0, '0},
         '{tspp_pkg::CH_LF, 1'b1, tspp_pkg::KIND_SAMPLE, 35'd0},
         '{tspp_pkg::CH_FF, 1'b0, 1'b0, '0}, '{tspp_pkg::CH_COMMA, 1'b0, 1'b0, '0},
         '{"9", 1'b0, 1'b0, '0}, '{"9", 1'b0, 1'b0, '0}, '{"9", 1'b0, 1'b0, '0},
         '{"9", 1'b0, 1'b0, '0}, '{"9", 1'b0, 1'b0, '0},
         '{tspp_pkg::CH_QUOTE, 1'b0, 1'b0, '0},
         '{"9", 1'b0, 1'b0, '0}, '{"9", 1'b0, 1'b0, '0},
         '{tspp_pkg::CH_NUL, 1'b0, 1'b0, '0},
         '{"9", 1'b0, 1'b0, '0}, '{tspp_pkg::CH_LPAREN, 1'b0, 1'b0, '0},
         '{"9", 1'b0, 1'b0, '0}, '{tspp_pkg::CH_RPAREN, 1'b0, 1'b0, '0},
         '{"9", 1'b0, 1'b0, '0}, '{tspp_pkg::CH_CR, 1'b0, 1'b0, '0},
         '{"9", 1'b0, 1'b0, '0}, '{tspp_pkg::CH_HASH, 1'b0, 1'b0, '0},
         '{"9", 1'b0, 1'b0, '0}, '{tspp_pkg::CH_COLON, 1'b0, 1'b0, '0},
         '{tspp_pkg::CH_DEL, 1'b0, 1'b0, '0}, '{tspp_pkg::CH_POINT, 1'b0, 1'b0, '0},
         '{tspp_pkg::CH_POINT, 1'b0, 1'b0, '0},
         '{tspp_pkg::CH_SPACE, 1'b1, tspp_pkg::KIND_TIME, 35'h0_FFFF_F000}
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[i])
         push_byte(opening[i].code, opening[i].typed, opening[i].kind, opening[i].value);

      tokens_made = 0;
      while (bytes_sent < $size(opening) + RANDOM_BYTES) begin
         steady = (tokens_made >= 50 && tokens_made < 75);
         if (tokens_made == 30) drain_tokens();
         emit_token();
         tokens_made++;
      end
      steady = 1'b0;
      drain_tokens();
      repeat (SETTLE) @(posedge clock);

      $display("%0d bytes sent, %0d random tokens; checked %0d time and %0d sample words",
               bytes_sent, tokens_made, times_seen, samples_seen);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", errors);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
